>>> sv/uud_pkg.sv
// Shared types, codes and helpers of the uudecode stream block.
package uud_pkg;

	typedef enum logic [1:0] {
		PH_SEEK   = 2'd0,
		PH_SKIP   = 2'd1,
		PH_DECODE = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_FINISHED  = 2'd1;
	localparam logic [1:0] KIND_NOBEGIN   = 2'd2;
	localparam logic [1:0] KIND_TRUNCATED = 2'd3;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [2:0] PREFIX_LEN = 3'd6;

	// Results one input word causes: up to three data bytes, then an optional status.
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      nbytes;
		logic            has_status;
		logic [1:0]      status;
	} pkt_t;

	function automatic logic [7:0] begin_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h62; // b
			3'd1:    c = 8'h65; // e
			3'd2:    c = 8'h67; // g
			3'd3:    c = 8'h69; // i
			3'd4:    c = 8'h6E; // n
			3'd5:    c = CH_SPACE;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [5:0] sextet(input logic [7:0] ch);
		logic [7:0] diff;
		diff = ch - CH_SPACE;
		return diff[5:0];
	endfunction

endpackage

>>> sv/uud_front.sv
// Front end: takes characters, tracks line state and builds result packets.
module uud_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_char,
	input  logic           end_of_input,
	input  logic           q_full,
	output logic           push,
	output uud_pkg::pkt_t  pkt
);

	uud_pkg::phase_t phase_q, phase_d;
	logic [2:0] pm_q, pm_d;
	logic       pf_q, pf_d;
	logic       als_q, als_d;
	logic [5:0] bl_q, bl_d;
	logic [1:0] gi_q, gi_d;
	logic [5:0] g_q [3];
	logic [5:0] g_d [3];

	logic       acc;
	logic       is_nl;
	logic [5:0] sext;
	logic [5:0] extra;
	logic [5:0] s0, s1, s2, s3;
	logic [1:0] k;
	logic [2:0] need;
	logic       grp_full;
	logic       hit;
	logic       cnt_zero;
	logic       close_flush;
	logic [2:0][7:0] fbytes;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign is_nl    = (in_char == uud_pkg::CH_NEWLINE);
	assign sext     = uud_pkg::sextet(in_char);
	assign cnt_zero = is_nl || (sext == 6'd0);
	assign hit      = (pm_q < uud_pkg::PREFIX_LEN) && (in_char == uud_pkg::begin_char(pm_q));

	// The character that completes a group; a short group is padded with zeros.
	assign extra = (end_of_input || is_nl) ? 6'd0 : sext;
	assign s0 = (gi_q == 2'd0) ? extra : g_q[0];
	assign s1 = (gi_q == 2'd1) ? extra : g_q[1];
	assign s2 = (gi_q == 2'd2) ? extra : g_q[2];
	assign s3 = (gi_q == 2'd3) ? extra : 6'd0;

	assign k        = (bl_q >= 6'd3) ? 2'd3 : bl_q[1:0];
	assign need     = (bl_q >= 6'd3) ? 3'd4 : (bl_q[2:0] + 3'd1);
	assign grp_full = ({1'b0, gi_q} + 3'd1) >= need;
	assign close_flush = (gi_q != 2'd0) && (bl_q != 6'd0);

	assign fbytes[0] = {s0, s1[5:4]};
	assign fbytes[1] = {s1[3:0], s2[5:2]};
	assign fbytes[2] = {s2[1:0], s3};

	// Phase sequencing
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			unique case (phase_q)
				uud_pkg::PH_SEEK: begin
					if (end_of_input)
						phase_d = uud_pkg::PH_DONE;
					else if (!is_nl && !pf_q && hit && pm_q == uud_pkg::PREFIX_LEN - 3'd1)
						phase_d = uud_pkg::PH_SKIP;
				end
				uud_pkg::PH_SKIP: begin
					if (end_of_input)
						phase_d = uud_pkg::PH_DONE;
					else if (is_nl)
						phase_d = uud_pkg::PH_DECODE;
				end
				uud_pkg::PH_DECODE: begin
					if (end_of_input || (als_q && cnt_zero))
						phase_d = uud_pkg::PH_DONE;
				end
				uud_pkg::PH_DONE: ;
				default: phase_d = phase_q;
			endcase
		end
	end

	// Line state and packet
	always_comb begin
		pm_d  = pm_q;
		pf_d  = pf_q;
		als_d = als_q;
		bl_d  = bl_q;
		gi_d  = gi_q;
		g_d   = g_q;
		pkt   = '0;
		if (acc) begin
			unique case (phase_q)
				uud_pkg::PH_SEEK: begin
					if (end_of_input) begin
						pkt.has_status = 1'b1;
						pkt.status     = uud_pkg::KIND_NOBEGIN;
					end else if (is_nl) begin
						pm_d  = 3'd0;
						pf_d  = 1'b0;
						als_d = 1'b1;
					end else begin
						als_d = 1'b0;
						if (!pf_q) begin
							if (hit)
								pm_d = pm_q + 3'd1;
							else
								pf_d = 1'b1;
						end
					end
				end
				uud_pkg::PH_SKIP: begin
					if (end_of_input) begin
						pkt.has_status = 1'b1;
						pkt.status     = uud_pkg::KIND_TRUNCATED;
					end else if (is_nl) begin
						als_d = 1'b1;
					end
				end
				uud_pkg::PH_DECODE: begin
					if (als_q && !end_of_input) begin
						if (cnt_zero) begin
							pkt.has_status = 1'b1;
							pkt.status     = uud_pkg::KIND_FINISHED;
						end else begin
							bl_d  = sext;
							gi_d  = 2'd0;
							g_d   = '{default: 6'd0};
							als_d = 1'b0;
						end
					end else if (end_of_input || is_nl) begin
						// close the line: decode a partial group, drop what is owed
						if (!als_q && close_flush) begin
							pkt.data   = fbytes;
							pkt.nbytes = k;
						end
						if (!als_q) begin
							bl_d  = 6'd0;
							gi_d  = 2'd0;
							g_d   = '{default: 6'd0};
							als_d = 1'b1;
						end
						if (end_of_input) begin
							pkt.has_status = 1'b1;
							pkt.status     = uud_pkg::KIND_TRUNCATED;
						end
					end else if (bl_q != 6'd0) begin
						if (grp_full) begin
							pkt.data   = fbytes;
							pkt.nbytes = k;
							bl_d       = bl_q - {4'd0, k};
							gi_d       = 2'd0;
							g_d        = '{default: 6'd0};
						end else begin
							g_d[gi_q] = sext;
							gi_d      = gi_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign push = acc && (pkt.nbytes != 2'd0 || pkt.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uud_pkg::PH_SEEK;
			pm_q    <= 3'd0;
			pf_q    <= 1'b0;
			als_q   <= 1'b1;
			bl_q    <= 6'd0;
			gi_q    <= 2'd0;
			g_q     <= '{default: 6'd0};
		end else begin
			phase_q <= phase_d;
			pm_q    <= pm_d;
			pf_q    <= pf_d;
			als_q   <= als_d;
			bl_q    <= bl_d;
			gi_q    <= gi_d;
			g_q     <= g_d;
		end
	end

endmodule

>>> sv/uud_fifo.sv
// Short packet queue between the front and back ends.
module uud_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  uud_pkg::pkt_t  wdata,
	input  logic           pop,
	output uud_pkg::pkt_t  rdata,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	uud_pkg::pkt_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

>>> sv/uud_back.sv
// Back end: unpacks queued packets into result words behind an output register.
module uud_back (
	input  logic           clk,
	input  logic           arst_n,
	input  uud_pkg::pkt_t  head,
	input  logic           q_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic [1:0]     kind,
	output logic           last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] kind_q;
	logic       last_q;

	logic       load;
	logic [2:0] total;
	logic       is_data;
	logic       is_last;

	assign total   = {1'b0, head.nbytes} + {2'b00, head.has_status};
	assign is_data = idx_q < head.nbytes;
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign load    = !q_empty && (!out_valid_q || !out_stall);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= is_data ? head.data[idx_q] : 8'h00;
			kind_q     <= is_data ? uud_pkg::KIND_DATA : head.status;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign kind      = kind_q;
	assign last      = last_q;

endmodule

>>> sv/uudecode_stream.sv
// Top level of the streaming uudecoder.
// Input channel: one text character per word (in_char), or an end marker
// (end_of_input). Lines are skipped until one starts with "begin "; each
// following line gives a count character and then four-character groups.
// Output channel: one result per word: out_byte, kind (data, finished,
// missing begin, truncated) and last, which marks the final result caused
// by an input word. Words causing no result produce nothing.
// Throughput: one character per cycle while the packet queue has room;
// the output side gives one result per cycle while out_stall is low, so a
// group yielding three bytes holds the back end and the queue absorbs that.
// A result passes through the packet queue and then the output register
// before it appears on out_valid.
// Reset clears line state to seeking the begin line and empties the queue.
// When out_stall is high the output word holds; once the queue fills,
// in_stall rises and input is held off. After a status word, all further
// input is taken and dropped until reset.
module uudecode_stream #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);

	uud_pkg::pkt_t wr_pkt, head_pkt;
	logic push, pop, q_full, q_empty;

	uud_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.push         (push),
		.pkt          (wr_pkt)
	);

	uud_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_pkt),
		.pop    (pop),
		.rdata  (head_pkt),
		.full   (q_full),
		.empty  (q_empty)
	);

	uud_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_pkt),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

	// A status word always closes its input word's results.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != uud_pkg::KIND_DATA |-> last)
		else $error("status word without last");

	// Status words carry no byte.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != uud_pkg::KIND_DATA |-> out_byte == 8'h00)
		else $error("status word with nonzero byte");

	// Nothing follows a delivered status word.
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && kind != uud_pkg::KIND_DATA |=> !out_valid)
		else $error("result after status word");

	// Packets never enter a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue overflow");

endmodule
